/* design/tes_pkg.sv */
package tes_pkg;

   localparam int unsigned ERROR_WIDTH_DEFAULT = 24;
   localparam int unsigned MAX_NOTES_DEFAULT = 65535;
   localparam int unsigned ABS_SUM_WIDTH = 40;
   localparam int unsigned SQ_SUM_WIDTH = 63;
   localparam int unsigned DELTA_SUM_WIDTH = 41;
   localparam int unsigned COUNT_WIDTH = 24;
   localparam int unsigned CORRECT_COUNT_WIDTH = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_WIDTH = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_DIV_SQ,
      ST_ROOT,
      ST_DIV_CHOP,
      ST_DONE
   } back_state_type;

endpackage

/* design/timing_error_statistics_unit.sv */
// channel   ports                        direction  transaction
// req       req_push/req_full + fields   in         push && !full
// rsp       rsp_pop/rsp_empty + fields   out        pop && !empty
// csr       csr_valid/csr_ready + data   in         valid && ready
// A note that is not last passes through the queue memory and the back result
// registers; the back end takes a new note once the held result is popped.
// A last note with correct notes runs two 63-step restoring divides and a
// 32-step root, plus a third divide when any pair exists.
// Synchronous active-high reset clears the queue, sums and the back FSM.
// The front stalls only when the 4-entry queue is full; a held result stalls
// the back end.
module timing_error_statistics_unit
   import tes_pkg::*;
#(
   parameter int unsigned ERROR_WIDTH = ERROR_WIDTH_DEFAULT,
   parameter int unsigned MAX_NOTES = MAX_NOTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [ERROR_WIDTH-1:0] req_timing_error,
   input  logic                   req_note_correct,
   input  logic                   req_last_note,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ERROR_WIDTH-1:0] csr_latency_correction,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [ERROR_WIDTH-1:0] rsp_corrected_error,
   output logic                   rsp_stats_valid,
   output logic [ERROR_WIDTH-1:0] rsp_mean_abs_error,
   output logic [ERROR_WIDTH-1:0] rsp_rms_error,
   output logic [ERROR_WIDTH-1:0] rsp_min_abs_error,
   output logic [ERROR_WIDTH-1:0] rsp_max_abs_error,
   output logic [ERROR_WIDTH-1:0] rsp_choppiness,
   output logic [CORRECT_COUNT_WIDTH-1:0] rsp_correct_count
);

   localparam int unsigned QW = 3*ERROR_WIDTH + 1 + ABS_SUM_WIDTH + SQ_SUM_WIDTH
                                + DELTA_SUM_WIDTH + 2*COUNT_WIDTH;

   logic [ERROR_WIDTH-1:0] lat_ff;
   logic accept, q_full, q_empty, q_pop;
   logic [ERROR_WIDTH-1:0] f_err, f_min, f_max, q_err, q_min, q_max;
   logic [ABS_SUM_WIDTH-1:0] f_abs, q_abs;
   logic [SQ_SUM_WIDTH-1:0] f_sq, q_sq;
   logic [COUNT_WIDTH-1:0] f_cnt, f_dcnt, q_cnt, q_dcnt;
   logic [DELTA_SUM_WIDTH-1:0] f_dsum, q_dsum;
   logic q_last;
   logic [QW-1:0] q_in, q_out;

   assign csr_ready = 1'b1;
   assign req_full = q_full;
   assign accept = req_push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) lat_ff <= '0;
      else if (csr_valid) lat_ff <= csr_latency_correction;
   end

   tes_front #(.ERROR_WIDTH(ERROR_WIDTH), .MAX_NOTES(MAX_NOTES)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .latency(lat_ff),
      .timing_error(req_timing_error), .note_correct(req_note_correct),
      .last_note(req_last_note), .corrected_error(f_err), .abs_sum(f_abs),
      .square_sum(f_sq), .sample_count(f_cnt), .delta_sum(f_dsum),
      .delta_count(f_dcnt), .min_seen(f_min), .max_seen(f_max)
   );

   assign q_in = {f_err, req_last_note, f_abs, f_sq, f_cnt, f_dsum, f_dcnt, f_min, f_max};
   assign {q_err, q_last, q_abs, q_sq, q_cnt, q_dsum, q_dcnt, q_min, q_max} = q_out;

   tes_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset), .push(req_push), .push_data(q_in),
      .full(q_full), .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   tes_back #(.ERROR_WIDTH(ERROR_WIDTH)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_pop(q_pop),
      .q_err(q_err), .q_last(q_last), .q_abs_sum(q_abs), .q_sq_sum(q_sq),
      .q_cnt(q_cnt), .q_dsum(q_dsum), .q_dcnt(q_dcnt), .q_min(q_min),
      .q_max(q_max), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_corrected_error(rsp_corrected_error), .rsp_stats_valid(rsp_stats_valid),
      .rsp_mean_abs_error(rsp_mean_abs_error), .rsp_rms_error(rsp_rms_error),
      .rsp_min_abs_error(rsp_min_abs_error), .rsp_max_abs_error(rsp_max_abs_error),
      .rsp_choppiness(rsp_choppiness), .rsp_correct_count(rsp_correct_count)
   );

endmodule

/* design/tes_front.sv */
module tes_front
   import tes_pkg::*;
#(
   parameter int unsigned ERROR_WIDTH = ERROR_WIDTH_DEFAULT,
   parameter int unsigned MAX_NOTES = MAX_NOTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [ERROR_WIDTH-1:0] latency,
   input  logic signed [ERROR_WIDTH-1:0] timing_error,
   input  logic                          note_correct,
   input  logic                          last_note,
   output logic signed [ERROR_WIDTH-1:0] corrected_error,
   output logic [ABS_SUM_WIDTH-1:0]      abs_sum,
   output logic [SQ_SUM_WIDTH-1:0]       square_sum,
   output logic [COUNT_WIDTH-1:0]        sample_count,
   output logic [DELTA_SUM_WIDTH-1:0]    delta_sum,
   output logic [COUNT_WIDTH-1:0]        delta_count,
   output logic [ERROR_WIDTH-1:0]        min_seen,
   output logic [ERROR_WIDTH-1:0]        max_seen
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = COUNT_WIDTH'(MAX_NOTES);
   localparam logic signed [ERROR_WIDTH:0] LO =
      -((ERROR_WIDTH+1)'(longint'(1) << (ERROR_WIDTH-1)));
   localparam logic signed [ERROR_WIDTH:0] HI = (ERROR_WIDTH+1)'((1 << (ERROR_WIDTH-1)) - 1);

   logic [ABS_SUM_WIDTH-1:0]   abs_sum_ff, abs_sum_in;
   logic [SQ_SUM_WIDTH-1:0]    sq_sum_ff, sq_sum_in;
   logic [COUNT_WIDTH-1:0]     cnt_ff, cnt_in, dcnt_ff, dcnt_in;
   logic [DELTA_SUM_WIDTH-1:0] dsum_ff, dsum_in;
   logic [ERROR_WIDTH-1:0]     min_ff, min_in, max_ff, max_in;
   logic                       prev_ok_ff, prev_ok_in;
   logic signed [ERROR_WIDTH-1:0] prev_err_ff, prev_err_in;

   logic signed [ERROR_WIDTH:0]   diff, diff_sat, dlt;
   logic signed [ERROR_WIDTH-1:0] err;
   logic [ERROR_WIDTH-1:0]        mag, dmag;
   logic [2*ERROR_WIDTH-1:0]      sq;
   logic [ABS_SUM_WIDTH:0]        abs_add;
   logic [SQ_SUM_WIDTH:0]         sq_add;
   logic [DELTA_SUM_WIDTH:0]      d_add;

   always_comb begin
      diff = (ERROR_WIDTH+1)'(timing_error) - (ERROR_WIDTH+1)'(latency);
      diff_sat = diff;
      if (diff < LO) diff_sat = LO;
      if (diff > HI) diff_sat = HI;
      err = note_correct ? diff_sat[ERROR_WIDTH-1:0] : timing_error;
      mag = err[ERROR_WIDTH-1] ? ERROR_WIDTH'(-err) : ERROR_WIDTH'(err);
      sq = mag * mag;
      dlt = (ERROR_WIDTH+1)'(err) - (ERROR_WIDTH+1)'(prev_err_ff);
      dmag = dlt[ERROR_WIDTH] ? ERROR_WIDTH'(-dlt) : ERROR_WIDTH'(dlt);
      abs_add = {1'b0, abs_sum_ff} + (ABS_SUM_WIDTH+1)'(mag);
      sq_add = {1'b0, sq_sum_ff} + (SQ_SUM_WIDTH+1)'(sq);
      d_add = {1'b0, dsum_ff} + (DELTA_SUM_WIDTH+1)'(dmag);
      corrected_error = err;
      abs_sum = abs_add[ABS_SUM_WIDTH] ? '1 : abs_add[ABS_SUM_WIDTH-1:0];
      square_sum = sq_add[SQ_SUM_WIDTH] ? '1 : sq_add[SQ_SUM_WIDTH-1:0];
      sample_count = (cnt_ff < CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;
      min_seen = (mag < min_ff) ? mag : min_ff;
      max_seen = (mag > max_ff) ? mag : max_ff;
      delta_sum = dsum_ff;
      delta_count = dcnt_ff;
      if (prev_ok_ff) begin
         delta_sum = d_add[DELTA_SUM_WIDTH] ? '1 : d_add[DELTA_SUM_WIDTH-1:0];
         delta_count = (dcnt_ff < CNT_MAX) ? dcnt_ff + 1'b1 : dcnt_ff;
      end
      if (!note_correct) begin
         abs_sum = abs_sum_ff;
         square_sum = sq_sum_ff;
         sample_count = cnt_ff;
         min_seen = min_ff;
         max_seen = max_ff;
         delta_sum = dsum_ff;
         delta_count = dcnt_ff;
      end
      abs_sum_in = abs_sum;
      sq_sum_in = square_sum;
      cnt_in = sample_count;
      dsum_in = delta_sum;
      dcnt_in = delta_count;
      min_in = min_seen;
      max_in = max_seen;
      prev_ok_in = note_correct;
      prev_err_in = err;
      if (last_note) begin
         abs_sum_in = '0;
         sq_sum_in = '0;
         cnt_in = '0;
         dsum_in = '0;
         dcnt_in = '0;
         min_in = '1;
         max_in = '0;
         prev_ok_in = 1'b0;
         prev_err_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_sum_ff <= '0;
         sq_sum_ff <= '0;
         cnt_ff <= '0;
         dsum_ff <= '0;
         dcnt_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
         prev_ok_ff <= 1'b0;
         prev_err_ff <= '0;
      end else if (accept) begin
         abs_sum_ff <= abs_sum_in;
         sq_sum_ff <= sq_sum_in;
         cnt_ff <= cnt_in;
         dsum_ff <= dsum_in;
         dcnt_ff <= dcnt_in;
         min_ff <= min_in;
         max_ff <= max_in;
         prev_ok_ff <= prev_ok_in;
         prev_err_ff <= prev_err_in;
      end
   end

endmodule

/* design/tes_queue.sv */
module tes_queue
   import tes_pkg::*;
#(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ff, rd_ff;
   logic [QUEUE_PTR_WIDTH:0]   cnt_ff;
   logic do_push, do_pop;

   assign full = cnt_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_PTR_WIDTH+1)'(do_push) - (QUEUE_PTR_WIDTH+1)'(do_pop);
      end
   end

endmodule

/* design/tes_back.sv */
module tes_back
   import tes_pkg::*;
#(
   parameter int unsigned ERROR_WIDTH = ERROR_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   output logic                       q_pop,
   input  logic [ERROR_WIDTH-1:0]     q_err,
   input  logic                       q_last,
   input  logic [ABS_SUM_WIDTH-1:0]   q_abs_sum,
   input  logic [SQ_SUM_WIDTH-1:0]    q_sq_sum,
   input  logic [COUNT_WIDTH-1:0]     q_cnt,
   input  logic [DELTA_SUM_WIDTH-1:0] q_dsum,
   input  logic [COUNT_WIDTH-1:0]     q_dcnt,
   input  logic [ERROR_WIDTH-1:0]     q_min,
   input  logic [ERROR_WIDTH-1:0]     q_max,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [ERROR_WIDTH-1:0]     rsp_corrected_error,
   output logic                       rsp_stats_valid,
   output logic [ERROR_WIDTH-1:0]     rsp_mean_abs_error,
   output logic [ERROR_WIDTH-1:0]     rsp_rms_error,
   output logic [ERROR_WIDTH-1:0]     rsp_min_abs_error,
   output logic [ERROR_WIDTH-1:0]     rsp_max_abs_error,
   output logic [ERROR_WIDTH-1:0]     rsp_choppiness,
   output logic [CORRECT_COUNT_WIDTH-1:0] rsp_correct_count
);

   localparam int unsigned DW = SQ_SUM_WIDTH;
   localparam int unsigned DCW = $clog2(DW + 1);
   localparam int unsigned RW = 32;
   localparam int unsigned RCW = 5;
   localparam logic [DW-1:0] EHALF = DW'(1) << (ERROR_WIDTH-1);
   localparam logic [DW-1:0] EMASK = (DW'(1) << ERROR_WIDTH) - 1'b1;

   back_state_type state_ff, state_in;
   logic [DW-1:0]  num_ff, num_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [COUNT_WIDTH:0] rem_ff, rem_in;
   logic [DCW-1:0] step_ff, step_in;
   logic [DW:0]    rv_ff, rv_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [RW+1:0]  rrem_ff, rrem_in;
   logic [RCW-1:0] rstep_ff, rstep_in;
   logic           full_ff, full_in;
   logic [ERROR_WIDTH-1:0] err_ff, err_in, mean_ff, mean_in, rms_ff, rms_in;
   logic [ERROR_WIDTH-1:0] chop_ff, chop_in, min_ff, min_in, max_ff, max_in;
   logic [ERROR_WIDTH-1:0] omin_ff, omin_in, omax_ff, omax_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, dcnt_ff, dcnt_in;
   logic [DELTA_SUM_WIDTH-1:0] dsum_ff, dsum_in;
   logic [SQ_SUM_WIDTH-1:0] sq_ff, sq_in;
   logic           sv_ff, sv_in;

   logic [COUNT_WIDTH:0] rshift, rsub;
   logic [RW+1:0] rtrial, rcur;
   logic          start, finish;

   assign rsp_empty = !full_ff;
   assign rsp_corrected_error = err_ff;
   assign rsp_stats_valid = sv_ff;
   assign rsp_mean_abs_error = mean_ff;
   assign rsp_rms_error = rms_ff;
   assign rsp_min_abs_error = omin_ff;
   assign rsp_max_abs_error = omax_ff;
   assign rsp_choppiness = chop_ff;
   assign rsp_correct_count = (cnt_ff > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                                                                  : cnt_ff[15:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start && q_last && q_cnt != '0) state_in = ST_DIV_MEAN;
         ST_DIV_MEAN: if (step_ff == '0) state_in = ST_DIV_SQ;
         ST_DIV_SQ:   if (step_ff == '0) state_in = ST_ROOT;
         ST_ROOT:     if (rstep_ff == '0) state_in = (dcnt_ff != '0) ? ST_DIV_CHOP : ST_DONE;
         ST_DIV_CHOP: if (step_ff == '0) state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      start = !q_empty && !full_ff && state_ff == ST_IDLE;
      q_pop = start;
      finish = (state_ff == ST_DONE);
      rshift = {rem_ff[COUNT_WIDTH-1:0], num_ff[DW-1]};
      rsub = rshift - {1'b0, (state_ff == ST_DIV_CHOP) ? dcnt_ff : cnt_ff};
      rcur = {rrem_ff[RW-1:0], rv_ff[DW -: 2]};
      rtrial = rcur - {root_ff, 2'b01};
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      rv_in = rv_ff;
      root_in = root_ff;
      rrem_in = rrem_ff;
      rstep_in = rstep_ff;
      full_in = full_ff;
      err_in = err_ff;
      mean_in = mean_ff;
      rms_in = rms_ff;
      chop_in = chop_ff;
      min_in = min_ff;
      max_in = max_ff;
      omin_in = omin_ff;
      omax_in = omax_ff;
      cnt_in = cnt_ff;
      dcnt_in = dcnt_ff;
      dsum_in = dsum_ff;
      sq_in = sq_ff;
      sv_in = sv_ff;
      if (rsp_pop && full_ff) full_in = 1'b0;
      if (start) begin
         err_in = q_err;
         sv_in = q_last;
         mean_in = '0;
         rms_in = '0;
         chop_in = '0;
         omin_in = '0;
         omax_in = '0;
         min_in = q_min;
         max_in = q_max;
         cnt_in = q_last ? q_cnt : '0;
         dcnt_in = q_dcnt;
         dsum_in = q_dsum;
         sq_in = q_sq_sum;
         num_in = DW'(q_abs_sum);
         quo_in = '0;
         rem_in = '0;
         step_in = DCW'(DW - 1);
         if (!(q_last && q_cnt != '0)) full_in = 1'b1;
      end
      if (state_ff == ST_DIV_MEAN || state_ff == ST_DIV_SQ || state_ff == ST_DIV_CHOP) begin
         num_in = num_ff << 1;
         if (!rsub[COUNT_WIDTH]) begin
            rem_in = rsub;
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rshift;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            num_in = (state_ff == ST_DIV_MEAN) ? sq_ff : DW'(dsum_ff);
            rem_in = '0;
            step_in = DCW'(DW - 1);
            if (state_ff == ST_DIV_MEAN)
               mean_in = (quo_in > EHALF) ? EHALF[ERROR_WIDTH-1:0] : quo_in[ERROR_WIDTH-1:0];
            if (state_ff == ST_DIV_SQ) begin
               rv_in = {1'b0, quo_in};
               root_in = '0;
               rrem_in = '0;
               rstep_in = '1;
            end
            if (state_ff == ST_DIV_CHOP)
               chop_in = (quo_in > EMASK) ? EMASK[ERROR_WIDTH-1:0] : quo_in[ERROR_WIDTH-1:0];
            quo_in = '0;
         end
      end
      if (state_ff == ST_ROOT) begin
         // quotient zero-extended to 64 bits gives 32 root digit pairs
         rv_in = rv_ff << 2;
         if (!rtrial[RW+1]) begin
            rrem_in = rtrial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rrem_in = rcur;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         rstep_in = rstep_ff - 1'b1;
         if (rstep_ff == '0)
            rms_in = (DW'(root_in) > EHALF) ? EHALF[ERROR_WIDTH-1:0]
                                             : root_in[ERROR_WIDTH-1:0];
      end
      if (finish) begin
         omin_in = min_ff;
         omax_in = max_ff;
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      rv_ff <= rv_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      rstep_ff <= rstep_in;
      err_ff <= err_in;
      mean_ff <= mean_in;
      rms_ff <= rms_in;
      chop_ff <= chop_in;
      min_ff <= min_in;
      max_ff <= max_in;
      omin_ff <= omin_in;
      omax_ff <= omax_in;
      cnt_ff <= cnt_in;
      dcnt_ff <= dcnt_in;
      dsum_ff <= dsum_in;
      sq_ff <= sq_in;
      sv_ff <= sv_in;
   end

endmodule

/* test/timing_error_statistics_unit_tb.sv */
module timing_error_statistics_unit_tb;
   import tes_pkg::*;

   localparam int unsigned EW = ERROR_WIDTH_DEFAULT;
   localparam longint ERR_LO = -(64'sd1 <<< (EW - 1));
   localparam longint ERR_HI = (64'sd1 <<< (EW - 1)) - 1;
   localparam longint unsigned EMASK = (64'd1 << EW) - 1;
   localparam longint unsigned EHALF = 64'd1 << (EW - 1);
   localparam longint unsigned ABS_SUM_MAX = (64'd1 << ABS_SUM_WIDTH) - 1;
   localparam longint unsigned SQ_SUM_MAX = (64'd1 << SQ_SUM_WIDTH) - 1;
   localparam longint unsigned DELTA_SUM_MAX = (64'd1 << DELTA_SUM_WIDTH) - 1;
   localparam int unsigned LAST_NOTE_CYCLES = 300;
   localparam int unsigned LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic [EW-1:0] corrected_error;
      logic stats_valid;
      logic [EW-1:0] mean_abs_error;
      logic [EW-1:0] rms_error;
      logic [EW-1:0] min_abs_error;
      logic [EW-1:0] max_abs_error;
      logic [EW-1:0] choppiness;
      logic [CORRECT_COUNT_WIDTH-1:0] correct_count;
   } note_result_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [EW-1:0] req_timing_error;
   logic req_note_correct;
   logic req_last_note;
   logic csr_valid;
   logic csr_ready;
   logic [EW-1:0] csr_latency_correction;
   logic rsp_empty;
   logic rsp_pop;
   logic [EW-1:0] rsp_corrected_error;
   logic rsp_stats_valid;
   logic [EW-1:0] rsp_mean_abs_error;
   logic [EW-1:0] rsp_rms_error;
   logic [EW-1:0] rsp_min_abs_error;
   logic [EW-1:0] rsp_max_abs_error;
   logic [EW-1:0] rsp_choppiness;
   logic [CORRECT_COUNT_WIDTH-1:0] rsp_correct_count;

   timing_error_statistics_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_timing_error(req_timing_error),
      .req_note_correct(req_note_correct),
      .req_last_note(req_last_note),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_latency_correction(csr_latency_correction),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_corrected_error(rsp_corrected_error),
      .rsp_stats_valid(rsp_stats_valid),
      .rsp_mean_abs_error(rsp_mean_abs_error),
      .rsp_rms_error(rsp_rms_error),
      .rsp_min_abs_error(rsp_min_abs_error),
      .rsp_max_abs_error(rsp_max_abs_error),
      .rsp_choppiness(rsp_choppiness),
      .rsp_correct_count(rsp_correct_count)
   );

   note_result_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned hold_requests = 0;

   longint latency;
   longint unsigned abs_total;
   longint unsigned square_total;
   int unsigned note_count;
   longint unsigned delta_total;
   int unsigned pair_count;
   longint unsigned min_mag;
   longint unsigned max_mag;
   bit prev_ok;
   longint prev_err;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("timing_error_statistics_unit: mismatch");
      $finish;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                               longint unsigned lim);
      if (a >= lim || b > lim - a) return lim;
      return a + b;
   endfunction

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? longint'(-x) : longint'(x);
   endfunction

   function automatic void clear_track();
      abs_total = 0;
      square_total = 0;
      note_count = 0;
      delta_total = 0;
      pair_count = 0;
      min_mag = EMASK;
      max_mag = 0;
      prev_ok = 1'b0;
      prev_err = 0;
   endfunction

   function automatic note_result_type track_statistics(logic [EW-1:0] te, logic ok,
                                                        logic last);
      note_result_type r;
      longint e;
      longint unsigned a;
      longint unsigned mean;
      longint unsigned rms;
      longint unsigned chop;
      e = longint'(signed'(te));
      if (ok) begin
         e = e - latency;
         if (e < ERR_LO) e = ERR_LO;
         if (e > ERR_HI) e = ERR_HI;
         a = magnitude(e);
         abs_total = add_sat(abs_total, a, ABS_SUM_MAX);
         square_total = add_sat(square_total, a * a, SQ_SUM_MAX);
         if (note_count < MAX_NOTES_DEFAULT) note_count++;
         if (a < min_mag) min_mag = a;
         if (a > max_mag) max_mag = a;
         if (prev_ok) begin
            delta_total = add_sat(delta_total, magnitude(e - prev_err), DELTA_SUM_MAX);
            if (pair_count < MAX_NOTES_DEFAULT) pair_count++;
         end
      end
      prev_ok = ok;
      prev_err = e;
      r = '{default: '0};
      r.corrected_error = e[EW-1:0];
      if (last) begin
         r.stats_valid = 1'b1;
         if (note_count > 0) begin
            mean = abs_total / note_count;
            rms = floor_sqrt(square_total / note_count);
            chop = 0;
            if (mean > EHALF) mean = EHALF;
            if (rms > EHALF) rms = EHALF;
            if (pair_count > 0) begin
               chop = delta_total / pair_count;
               if (chop > EMASK) chop = EMASK;
            end
            r.mean_abs_error = mean[EW-1:0];
            r.rms_error = rms[EW-1:0];
            r.min_abs_error = min_mag[EW-1:0];
            r.max_abs_error = max_mag[EW-1:0];
            r.choppiness = chop[EW-1:0];
            r.correct_count = note_count > 16'hFFFF ? 16'hFFFF : note_count[15:0];
         end
         clear_track();
      end
      return r;
   endfunction

   task automatic send_note(logic [EW-1:0] te, logic ok, logic last);
      @(negedge clock);
      req_push <= 1'b1;
      req_timing_error <= te;
      req_note_correct <= ok;
      req_last_note <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_results.push_back(track_statistics(te, ok, last));
   endtask

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      pause_sender(0);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LAST_NOTE_CYCLES) @(negedge clock);
   endtask

   task automatic write_latency(longint value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_latency_correction <= value[EW-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      latency = longint'(signed'(value[EW-1:0]));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [EW-1:0] pick_error();
      case ($urandom_range(0, 9))
         0: return ERR_HI[EW-1:0];
         1: return ERR_LO[EW-1:0];
         2, 3: return EW'($urandom);
         default: return EW'($urandom_range(0, 4000) - 2000);
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         note_result_type exp_r;
         if (pending_results.size() == 0) begin
            $display("%0t: result with no transaction expected, corrected_error %h",
                     $time, rsp_corrected_error);
            mismatch_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_corrected_error !== exp_r.corrected_error ||
                rsp_stats_valid !== exp_r.stats_valid ||
                rsp_mean_abs_error !== exp_r.mean_abs_error ||
                rsp_rms_error !== exp_r.rms_error ||
                rsp_min_abs_error !== exp_r.min_abs_error ||
                rsp_max_abs_error !== exp_r.max_abs_error ||
                rsp_choppiness !== exp_r.choppiness ||
                rsp_correct_count !== exp_r.correct_count) begin
               $display("%0t: expected err %h sv %b mean %h rms %h min %h max %h chop %h n %h",
                        $time, exp_r.corrected_error, exp_r.stats_valid,
                        exp_r.mean_abs_error, exp_r.rms_error, exp_r.min_abs_error,
                        exp_r.max_abs_error, exp_r.choppiness, exp_r.correct_count);
               $display("%0t: actual   err %h sv %b mean %h rms %h min %h max %h chop %h n %h",
                        $time, rsp_corrected_error, rsp_stats_valid, rsp_mean_abs_error,
                        rsp_rms_error, rsp_min_abs_error, rsp_max_abs_error,
                        rsp_choppiness, rsp_correct_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned hold_served;
      int unsigned hold_left;
      int unsigned phase_left;
      int unsigned pop_rate;
      hold_served = 0;
      hold_left = 0;
      phase_left = 0;
      pop_rate = 100;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
               0, 1: pop_rate = 100;
               2: pop_rate = 50;
               default: pop_rate = 15;
            endcase
         end
         phase_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(1, 100) <= pop_rate);
         end
      end
   end

   task automatic test_field_extremes();
      send_note(ERR_HI[EW-1:0], 1'b1, 1'b0);
      send_note(ERR_LO[EW-1:0], 1'b1, 1'b0);
      send_note('0, 1'b1, 1'b0);
      send_note('1, 1'b0, 1'b0);
      send_note(EW'(-5), 1'b1, 1'b1);
      send_note(EW'(77), 1'b0, 1'b0);
      send_note(ERR_HI[EW-1:0], 1'b0, 1'b1);
      send_note(EW'(1234), 1'b1, 1'b1);
      send_note(EW'(-9), 1'b0, 1'b1);
   endtask

   task automatic test_latency_saturation();
      write_latency(ERR_LO);
      send_note(ERR_HI[EW-1:0], 1'b1, 1'b0);
      send_note(EW'(100), 1'b1, 1'b0);
      send_note(ERR_LO[EW-1:0], 1'b0, 1'b0);
      send_note(ERR_LO[EW-1:0], 1'b1, 1'b1);
      write_latency(ERR_HI);
      send_note(ERR_LO[EW-1:0], 1'b1, 1'b0);
      send_note(ERR_HI[EW-1:0], 1'b1, 1'b0);
      send_note(ERR_HI[EW-1:0], 1'b1, 1'b0);
      send_note(EW'(-100), 1'b1, 1'b1);
      write_latency(0);
   endtask

   task automatic send_track(int unsigned notes, int unsigned ok_pct, bit bursty);
      for (int unsigned i = 0; i < notes; i++) begin
         if (bursty && $urandom_range(0, 7) == 0) pause_sender($urandom_range(0, 12));
         send_note(pick_error(), $urandom_range(1, 100) <= ok_pct, i == notes - 1);
      end
   endtask

   task automatic test_random_tracks(int unsigned total);
      int unsigned sent;
      int unsigned n;
      longint lat_choices[6];
      sent = 0;
      lat_choices = '{0, 1, -1, ERR_HI, ERR_LO, 0};
      for (int s = 0; s < 6; s++) begin
         if (s == 5) write_latency(longint'(signed'(EW'($urandom))));
         else write_latency(lat_choices[s]);
         while (sent < total * (s + 1) / 6) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
            send_track(n, ($urandom_range(0, 4) == 0) ? 20 : 90, 1'b1);
            sent += n;
         end
      end
   endtask

   task automatic test_full_queue();
      wait_drained();
      hold_requests++;
      send_track(40, 80, 1'b0);
      pause_sender(0);
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_timing_error = '0;
      req_note_correct = 1'b0;
      req_last_note = 1'b0;
      csr_valid = 1'b0;
      csr_latency_correction = '0;
      latency = 0;
      clear_track();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_latency_saturation();
      test_full_queue();
      test_random_tracks(1050);
      wait_drained();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("timing_error_statistics_unit: match");
      end else begin
         $display("timing_error_statistics_unit: mismatch");
      end
      $finish;
   end

endmodule

/* files.f */
design/tes_pkg.sv
design/tes_front.sv
design/tes_queue.sv
design/tes_back.sv
design/timing_error_statistics_unit.sv
test/timing_error_statistics_unit_tb.sv
